// ===== src/pfc_pkg.sv =====
// package for the prime factor counter: widths, limits, helpers and the
// command/status types between controller and datapath
// no dependencies
`default_nettype none

package pfc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int TOTAL_W        = 5;
  localparam int DIST_W         = 4;
  localparam int FIRST_DIVISOR  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic hit_first;
    logic hit_again;
    logic step_div;
    logic finish;
  } pfc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_gt_q;
    logic rem_zero;
    logic n_small;
    logic out_busy;
  } pfc_sts_t;

  function automatic logic [TOTAL_W-1:0] sat_inc_total(input logic [TOTAL_W-1:0] x);
    return (x == TOTAL_MAX) ? x : x + TOTAL_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] sat_inc_dist(input logic [DIST_W-1:0] x);
    return (x == DIST_MAX) ? x : x + DIST_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/pfc_in_if.sv =====
// input channel: valid/ready handshake carrying the value to factor
// depends on nothing
`default_nettype none

interface pfc_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== src/pfc_out_if.sv =====
// result channel: valid/ready handshake carrying counts and running records
// uses pfc_pkg for the count widths
`default_nettype none

interface pfc_out_if
  import pfc_pkg::*;
#(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [TOTAL_W-1:0]    total_factors;
  logic [DIST_W-1:0]     distinct_factors;
  logic [TOTAL_W-1:0]    best_total_count;
  logic [VALUE_BITS-1:0] best_total_value;
  logic [DIST_W-1:0]     best_distinct_count;
  logic [VALUE_BITS-1:0] best_distinct_value;

  modport source (output valid, output total_factors, output distinct_factors,
                  output best_total_count, output best_total_value,
                  output best_distinct_count, output best_distinct_value,
                  input ready);
  modport sink   (input valid, input total_factors, input distinct_factors,
                  input best_total_count, input best_total_value,
                  input best_distinct_count, input best_distinct_value,
                  output ready);
endinterface

`default_nettype wire

// ===== src/pfc_div.sv =====
// restoring divider, one quotient bit per cycle, gives quotient and remainder
// standalone, no package needed
`default_nettype none

module pfc_div #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quo,
  output logic [VALUE_BITS-1:0]      rem
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VALUE_BITS]) begin
        rem_nxt = diff[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== src/pfc_dp.sv =====
// datapath: remaining value, trial divisor, counters, records and result register
// uses pfc_pkg and the divider pfc_div
`default_nettype none

module pfc_dp
  import pfc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pfc_cmd_t              cmd,
  output pfc_sts_t                   sts,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [TOTAL_W-1:0]         out_total,
  output logic [DIST_W-1:0]          out_dist,
  output logic [TOTAL_W-1:0]         out_best_total,
  output logic [VALUE_BITS-1:0]      out_best_total_value,
  output logic [DIST_W-1:0]          out_best_dist,
  output logic [VALUE_BITS-1:0]      out_best_dist_value
);

  logic [VALUE_BITS-1:0] value_r, n_r, div_r;
  logic [TOTAL_W-1:0]    t_r;
  logic [DIST_W-1:0]     d_r;
  logic [TOTAL_W-1:0]    best_t_r;
  logic [VALUE_BITS-1:0] best_t_val_r;
  logic [DIST_W-1:0]     best_d_r;
  logic [VALUE_BITS-1:0] best_d_val_r;
  logic                  out_valid_r;
  logic [TOTAL_W-1:0]    o_t_r, o_bt_r;
  logic [DIST_W-1:0]     o_d_r, o_bd_r;
  logic [VALUE_BITS-1:0] o_btv_r, o_bdv_r;

  logic                  div_done;
  logic [VALUE_BITS-1:0] quo, rem;
  logic                  n_gt_one;
  logic [TOTAL_W-1:0]    fin_t;
  logic [DIST_W-1:0]     fin_d;
  logic                  new_t, new_d;

  pfc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (n_r),
    .divisor  (div_r),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign n_gt_one = (n_r > VALUE_BITS'(1));
  assign fin_t    = n_gt_one ? sat_inc_total(t_r) : t_r;
  assign fin_d    = n_gt_one ? sat_inc_dist(d_r) : d_r;
  assign new_t    = (fin_t > best_t_r);
  assign new_d    = (fin_d > best_d_r);

  always_comb begin
    sts.div_done = div_done;
    sts.div_gt_q = (div_r > quo);
    sts.rem_zero = (rem == '0);
    sts.n_small  = (n_r < VALUE_BITS'(FIRST_DIVISOR));
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_t_r     <= '0;
      best_t_val_r <= '0;
      best_d_r     <= '0;
      best_d_val_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (new_t) begin
          best_t_r     <= fin_t;
          best_t_val_r <= value_r;
        end
        if (new_d) begin
          best_d_r     <= fin_d;
          best_d_val_r <= value_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (cmd.load) begin
      value_r <= in_value;
      n_r     <= in_value;
      div_r   <= VALUE_BITS'(FIRST_DIVISOR);
      t_r     <= '0;
      d_r     <= '0;
    end else begin
      if (cmd.hit_first || cmd.hit_again) begin
        n_r <= quo;
        t_r <= sat_inc_total(t_r);
      end
      if (cmd.hit_first) begin
        d_r <= sat_inc_dist(d_r);
      end
      if (cmd.step_div) begin
        div_r <= div_r + VALUE_BITS'(1);
      end
    end

    if (cmd.finish) begin
      o_t_r   <= fin_t;
      o_d_r   <= fin_d;
      o_bt_r  <= new_t ? fin_t : best_t_r;
      o_btv_r <= new_t ? value_r : best_t_val_r;
      o_bd_r  <= new_d ? fin_d : best_d_r;
      o_bdv_r <= new_d ? value_r : best_d_val_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_total            = o_t_r;
  assign out_dist             = o_d_r;
  assign out_best_total       = o_bt_r;
  assign out_best_total_value = o_btv_r;
  assign out_best_dist        = o_bd_r;
  assign out_best_dist_value  = o_bdv_r;

endmodule

`default_nettype wire

// ===== src/pfc_ctrl.sv =====
// controller: sequences load, trial divisions, divisor steps and result hand-off
// uses pfc_pkg for command and status types
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pfc_sts_t sts,
  output pfc_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       inner_r, inner_nxt;

  always_comb begin
    state_nxt = state_r;
    inner_nxt = inner_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          inner_nxt = 1'b0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (sts.n_small) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_START;
          if (inner_r) begin
            // keep dividing out the same prime
            if (sts.rem_zero) begin
              cmd.hit_again = 1'b1;
            end else begin
              cmd.step_div = 1'b1;
              inner_nxt    = 1'b0;
            end
          end else if (sts.div_gt_q) begin
            state_nxt = ST_FINISH;
          end else if (sts.rem_zero) begin
            cmd.hit_first = 1'b1;
            inner_nxt     = 1'b1;
          end else begin
            cmd.step_div = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inner_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inner_r <= inner_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/prime_factor_count_max.sv =====
// top level: trial-division prime factor counter with running records
// uses pfc_pkg, pfc_in_if, pfc_out_if, pfc_ctrl, pfc_dp (and pfc_div below it)
//
//   channel | modport | payload
//   in_s    | sink    | value
//   out_m   | source  | total_factors, distinct_factors, best_total_count,
//           |         | best_total_value, best_distinct_count, best_distinct_value
//
// one item at a time; each trial, and each further division by a prime already
// found, is one pass of the bit-serial divider
// reset is synchronous, active low, and clears control state and the records
// a finished result waits in the output register; the next item is taken
// meanwhile and only its hand-off stalls until the output is free
`default_nettype none

module prime_factor_count_max
  import pfc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pfc_in_if.sink        in_s,
  pfc_out_if.source     out_m
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;
  logic     in_ready;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfc_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_value             (in_s.value),
    .out_ready            (out_m.ready),
    .out_valid            (out_m.valid),
    .out_total            (out_m.total_factors),
    .out_dist             (out_m.distinct_factors),
    .out_best_total       (out_m.best_total_count),
    .out_best_total_value (out_m.best_total_value),
    .out_best_dist        (out_m.best_distinct_count),
    .out_best_dist_value  (out_m.best_distinct_value)
  );

  assign in_s.ready = in_ready;

endmodule

`default_nettype wire

// ===== test/prime_factor_count_max_test.sv =====
`timescale 1ns / 100ps
// testbench for prime_factor_count_max: sends values to factor, predicts counts and records
// and checks every result in order; uses pfc_pkg, pfc_in_if, pfc_out_if and the top level
`default_nettype none

module prime_factor_count_max_test;
  import pfc_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [DIST_W-1:0]  distinct;
    logic [TOTAL_W-1:0] top_total;
    value_t             top_total_value;
    logic [DIST_W-1:0]  top_distinct;
    value_t             top_distinct_value;
  } factor_counts_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   error_count;
  bit   idling;

  factor_counts_t expected_counts[$];

  logic [TOTAL_W-1:0] record_total;
  value_t             record_total_value;
  logic [DIST_W-1:0]  record_distinct;
  value_t             record_distinct_value;

  pfc_in_if  #(.VALUE_BITS(VALUE_BITS)) in_if ();
  pfc_out_if #(.VALUE_BITS(VALUE_BITS)) out_if ();

  prime_factor_count_max #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // trial division, divisors upward from two
  function automatic factor_counts_t factor_value(input value_t v);
    factor_counts_t   r;
    longint unsigned  n;
    longint unsigned  d;
    int               t;
    int               k;
    n = v;
    d = FIRST_DIVISOR;
    t = 0;
    k = 0;
    if (n >= FIRST_DIVISOR) begin
      while (d <= n / d) begin
        if (n % d == 0) begin
          k++;
          while (n % d == 0) begin
            n = n / d;
            t++;
          end
        end
        d++;
      end
      if (n > 1) begin
        t++;
        k++;
      end
    end
    r = '0;
    r.total = (t > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(t);
    r.distinct = (k > DIST_MAX) ? DIST_MAX : DIST_W'(k);
    return r;
  endfunction

  task automatic predict_counts(input value_t v);
    factor_counts_t r;
    r = factor_value(v);
    if (r.total > record_total) begin
      record_total = r.total;
      record_total_value = v;
    end
    if (r.distinct > record_distinct) begin
      record_distinct = r.distinct;
      record_distinct_value = v;
    end
    r.top_total = record_total;
    r.top_total_value = record_total_value;
    r.top_distinct = record_distinct;
    r.top_distinct_value = record_distinct_value;
    expected_counts.push_back(r);
  endtask

  task automatic send_value(input value_t v);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    predict_counts(v);
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 15) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input value_t expected_v,
                                      input value_t actual_v);
    if (expected_v !== actual_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected_v,
               actual_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual total %0d", $time,
                 out_if.total_factors);
        error_count++;
      end else begin
        factor_counts_t e;
        e = expected_counts.pop_front();
        check_field("total_factors", e.total, out_if.total_factors);
        check_field("distinct_factors", e.distinct, out_if.distinct_factors);
        check_field("best_total_count", e.top_total, out_if.best_total_count);
        check_field("best_total_value", e.top_total_value, out_if.best_total_value);
        check_field("best_distinct_count", e.top_distinct, out_if.best_distinct_count);
        check_field("best_distinct_value", e.top_distinct_value,
                    out_if.best_distinct_value);
      end
    end
  end

  // mostly smooth numbers so trial division stays short
  function automatic value_t random_value();
    int unsigned     primes[9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
    longint unsigned v;
    longint unsigned p;
    int              sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      v = $urandom_range(2, 1 << 20);
    else if (sel == 1)
      v = $urandom_range(0, 1);
    else
      v = $urandom_range(1, 4095);
    if (sel != 1) begin
      repeat ($urandom_range(0, 30)) begin
        p = primes[$urandom_range(0, 8)];
        if (v * p < (64'd1 << VALUE_BITS))
          v = v * p;
      end
    end
    return value_t'(v);
  endfunction

  task automatic test_zero_and_one();
    send_value(0);
    send_value(1);
    send_value(0);
    send_value(1);
  endtask

  task automatic test_record_ties();
    send_value(2);
    send_value(3);
    send_value(4);
    send_value(9);
    send_value(6);
    send_value(10);
    send_value(8);
  endtask

  task automatic test_prime_powers();
    send_value(49);
    send_value(121);
    send_value(12);
    send_value(18);
    send_value(30);
  endtask

  task automatic test_field_extremes();
    send_value(value_t'(1) << (VALUE_BITS - 1));
    send_value(223092870);
    send_value('1 - value_t'(1));
    send_value('1);
    send_value(0);
  endtask

  task automatic test_drain_pause();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    send_value(random_value());
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    idling = 1'b0;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    cycle_count = 0;
    error_count = 0;
    idling = 1'b1;
    record_total = '0;
    record_total_value = '0;
    record_distinct = '0;
    record_distinct_value = '0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_and_one();
    test_record_ties();
    test_prime_powers();
    test_field_extremes();
    test_drain_pause();
    test_random_values(80);
    test_back_to_back(20);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
